>>> design/ssdc_pkg.sv
`timescale 1ns / 1ps

package ssdc_pkg;

  // Field widths of the stream words and the register
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned DIV_W     = 11;
  localparam int unsigned TOTAL_W   = 48;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned RES_OUT_W = 10;
  localparam int unsigned OUT_DATA_W = 64;

  localparam int unsigned DEF_MAX_DIVISOR = 1024;

  // Bits retired per cycle by the remainder steppers
  localparam int unsigned DIGIT_W = 4;

  // Epoch tag kept beside each count; the all-ones tag marks a swept entry
  localparam int unsigned EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_STALE = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = EPOCH_STALE - 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [2:0] {
    BK_SWEEP,
    BK_IDLE,
    BK_START,
    BK_REDUCE,
    BK_READ,
    BK_LOOK
  } bk_state_e;

  typedef struct packed {
    logic sweeping;
    logic finishing;
  } bk_status_t;

endpackage

>>> design/ssdc_front.sv
`timescale 1ns / 1ps

module ssdc_front #(
  parameter int unsigned MAX_DIVISOR = ssdc_pkg::DEF_MAX_DIVISOR,
  localparam int unsigned KW = $clog2(MAX_DIVISOR + 1),
  localparam int unsigned RW = $clog2(MAX_DIVISOR)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ssdc_pkg::VALUE_W-1:0] in_value_i,
  input  logic                         in_first_i,
  input  logic [KW-1:0]                k_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [RW-1:0]                out_residue_o,
  output logic                         out_first_o
);
  import ssdc_pkg::*;

  localparam int unsigned NDIG = VALUE_W / DIGIT_W;
  localparam int unsigned CW   = $clog2(NDIG + 1);

  logic                busy_q;
  logic                neg_q;
  logic                first_q;
  logic [VALUE_W-1:0]  mag_q;
  logic [KW-1:0]       rem_q;
  logic [CW-1:0]       cnt_q;
  logic                done;

  // Shift one digit into a remainder that stays below k
  function automatic logic [KW-1:0] mod_digit(logic [KW-1:0] rem, logic [DIGIT_W-1:0] dig,
                                              logic [KW-1:0] k);
    logic [KW:0] r;
    r = {1'b0, rem};
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      r = {r[KW-1:0], dig[i]};
      if (r >= {1'b0, k}) begin
        r = r - {1'b0, k};
      end
    end
    return r[KW-1:0];
  endfunction

  assign done        = (cnt_q == CW'(NDIG));
  assign in_ready_o  = !busy_q;
  assign out_valid_o = busy_q && done;
  assign out_first_o = first_q;

  // Negative values: fold the magnitude's remainder back into 0..k-1
  always_comb begin
    if (neg_q && (rem_q != '0)) begin
      out_residue_o = RW'(k_i - rem_q);
    end else begin
      out_residue_o = RW'(rem_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      neg_q   <= 1'b0;
      first_q <= 1'b0;
      mag_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
    end else if (in_valid_i && in_ready_o) begin
      busy_q  <= 1'b1;
      neg_q   <= in_value_i[VALUE_W-1];
      first_q <= in_first_i;
      mag_q   <= in_value_i[VALUE_W-1] ? (~in_value_i + 1'b1) : in_value_i;
      rem_q   <= '0;
      cnt_q   <= '0;
    end else if (busy_q && !done) begin
      rem_q <= mod_digit(rem_q, mag_q[VALUE_W-1 -: DIGIT_W], k_i);
      mag_q <= mag_q << DIGIT_W;
      cnt_q <= cnt_q + 1'b1;
    end else if (out_valid_o && out_ready_i) begin
      busy_q <= 1'b0;
    end
  end

endmodule

>>> design/ssdc_queue.sv
`timescale 1ns / 1ps

module ssdc_queue #(
  parameter int unsigned W = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);
  import ssdc_pkg::*;

  logic [W-1:0] slot_q [2];
  logic         wr_q;
  logic         rd_q;
  logic [1:0]   fill_q;
  logic         push;
  logic         pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_data_o   = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      unique case ({push, pop})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

>>> design/ssdc_back.sv
`timescale 1ns / 1ps

module ssdc_back #(
  parameter int unsigned MAX_DIVISOR = ssdc_pkg::DEF_MAX_DIVISOR,
  localparam int unsigned KW = $clog2(MAX_DIVISOR + 1),
  localparam int unsigned RW = $clog2(MAX_DIVISOR)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [KW-1:0]                   k_i,
  input  logic                            q_valid_i,
  output logic                            q_ready_o,
  input  logic [RW-1:0]                   q_residue_i,
  input  logic                            q_first_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ssdc_pkg::OUT_DATA_W-1:0] out_data_o,
  output ssdc_pkg::bk_status_t            status_o
);
  import ssdc_pkg::*;

  localparam int unsigned SW   = RW + 1;
  localparam int unsigned NDIG = (SW + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned SD   = NDIG * DIGIT_W;
  localparam int unsigned CW   = $clog2(NDIG + 1);
  localparam int unsigned MW   = EPOCH_W + COUNT_W;

  logic [MW-1:0]         mem [MAX_DIVISOR];

  bk_state_e             state_q;
  bk_state_e             state_d;
  logic                  held_q;
  logic                  first_q;
  logic [RW-1:0]         vr_q;
  logic [RW-1:0]         rr_q;
  logic [TOTAL_W-1:0]    total_q;
  logic [EPOCH_W-1:0]    epoch_q;
  logic [RW-1:0]         sweep_q;
  logic [SD-1:0]         sum_q;
  logic [KW-1:0]         rem_q;
  logic [CW-1:0]         cnt_q;
  logic [MW-1:0]         rd_q;
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic                  sweep_last;
  logic                  red_done;
  logic                  pop;
  logic                  mem_we;
  logic [RW-1:0]         mem_waddr;
  logic [MW-1:0]         mem_wdata;
  logic                  hit;
  logic [COUNT_W-1:0]    cnt_cur;
  logic [COUNT_W-1:0]    cnt_next;
  logic [TOTAL_W:0]      total_sum;
  logic [TOTAL_W-1:0]    total_next;

  function automatic logic [KW-1:0] mod_digit(logic [KW-1:0] rem, logic [DIGIT_W-1:0] dig,
                                              logic [KW-1:0] k);
    logic [KW:0] r;
    r = {1'b0, rem};
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      r = {r[KW-1:0], dig[i]};
      if (r >= {1'b0, k}) begin
        r = r - {1'b0, k};
      end
    end
    return r[KW-1:0];
  endfunction

  assign sweep_last = (sweep_q == RW'(MAX_DIVISOR - 1));
  assign red_done   = (cnt_q == CW'(NDIG));
  assign pop        = q_valid_i && q_ready_o;

  // Count lookup: an entry from an older epoch reads as the cleared table
  assign hit      = (rd_q[MW-1 -: EPOCH_W] == epoch_q);
  assign cnt_cur  = hit ? rd_q[COUNT_W-1:0] : ((rr_q == '0) ? COUNT_W'(1) : '0);
  assign cnt_next = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
  assign total_sum  = {1'b0, total_q} + (TOTAL_W + 1)'(cnt_cur);
  assign total_next = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_SWEEP: begin
        if (sweep_last) begin
          state_d = held_q ? BK_START : BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (pop) begin
          state_d = BK_START;
        end
      end
      BK_START: begin
        if (first_q && (epoch_q == EPOCH_LAST)) begin
          state_d = BK_SWEEP;
        end else begin
          state_d = BK_REDUCE;
        end
      end
      BK_REDUCE: begin
        if (red_done) begin
          state_d = BK_READ;
        end
      end
      BK_READ: state_d = BK_LOOK;
      BK_LOOK: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_ready_o = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = sweep_q;
    mem_wdata = {EPOCH_STALE, {COUNT_W{1'b0}}};
    unique case (state_q)
      BK_SWEEP: mem_we = 1'b1;
      BK_IDLE:  q_ready_o = !out_valid_q;
      BK_LOOK: begin
        mem_we    = 1'b1;
        mem_waddr = rr_q;
        mem_wdata = {epoch_q, cnt_next};
      end
      default: ;
    endcase
    status_o.sweeping  = (state_q == BK_SWEEP);
    status_o.finishing = (state_q == BK_LOOK);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Count table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_q == BK_READ) begin
      rd_q <= mem[rr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_SWEEP;
      held_q      <= 1'b0;
      first_q     <= 1'b0;
      vr_q        <= '0;
      rr_q        <= '0;
      total_q     <= '0;
      epoch_q     <= '0;
      sweep_q     <= '0;
      sum_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        BK_SWEEP: begin
          sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
        end
        BK_IDLE: begin
          if (pop) begin
            held_q  <= 1'b1;
            first_q <= q_first_i;
            vr_q    <= q_residue_i;
          end
        end
        BK_START: begin
          if (first_q) begin
            total_q <= '0;
            rr_q    <= '0;
            first_q <= 1'b0;
            epoch_q <= (epoch_q == EPOCH_LAST) ? '0 : epoch_q + 1'b1;
            sum_q   <= SD'(vr_q);
          end else begin
            sum_q <= SD'({1'b0, rr_q} + {1'b0, vr_q});
          end
          rem_q <= '0;
          cnt_q <= '0;
        end
        BK_REDUCE: begin
          if (!red_done) begin
            rem_q <= mod_digit(rem_q, sum_q[SD-1 -: DIGIT_W], k_i);
            sum_q <= sum_q << DIGIT_W;
            cnt_q <= cnt_q + 1'b1;
          end else begin
            rr_q <= RW'(rem_q);
          end
        end
        BK_LOOK: begin
          total_q     <= total_next;
          held_q      <= 1'b0;
          out_valid_q <= 1'b1;
          out_data_q  <= OUT_DATA_W'({RES_OUT_W'(rr_q), total_next});
        end
        default: ;
      endcase
    end
  end

endmodule

>>> design/subarray_sum_divisible_counter.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/tready         tdata: value[31:0]; tuser: first
// m_axis    out  m_axis_tvalid/tready         tdata: pair_total[47:0], prefix_residue[57:48]
// cfg       in   cfg_valid/cfg_ready          divisor[10:0]
//
// The front handles one word at a time: accept, eight 4-bit steps reducing the magnitude
// modulo the divisor, hand-off. The back adds the prefix residue, reduces again (3 steps
// at the default depth) and updates the count table, then pops the next word. The front
// sets the rate. A result not taken holds the back; the two-word queue then fills and
// stalls the front. After reset and on every 255th sequence start the back sweeps the
// table with input held off; other starts advance the epoch tag.
module subarray_sum_divisible_counter #(
  parameter int unsigned MAX_DIVISOR = ssdc_pkg::DEF_MAX_DIVISOR
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [ssdc_pkg::VALUE_W-1:0]    s_axis_tdata_i,   // [31:0] value
  input  logic                            s_axis_tuser_i,   // [0] first
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [ssdc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,   // [47:0] pair_total,
                                                            // [57:48] prefix_residue
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ssdc_pkg::DIV_W-1:0]      cfg_data_i        // [10:0] divisor
);
  import ssdc_pkg::*;

  localparam int unsigned KW = $clog2(MAX_DIVISOR + 1);
  localparam int unsigned RW = $clog2(MAX_DIVISOR);

  logic [DIV_W-1:0] div_q;
  logic [KW-1:0]    keff;
  logic             fr_ready;
  logic             fr_valid;
  logic [RW-1:0]    fr_residue;
  logic             fr_first;
  logic             q_push_ready;
  logic             q_pop_valid;
  logic             q_pop_ready;
  logic [RW:0]      q_pop_data;
  bk_status_t       bk_stat;

  // Divisor register; always ready, write it only while no word is in flight
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= DIV_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      div_q <= cfg_data_i;
    end
  end

  // Map zero to one and clamp to the table depth
  always_comb begin
    if (div_q == '0) begin
      keff = KW'(1);
    end else if (32'(div_q) > 32'(MAX_DIVISOR)) begin
      keff = KW'(MAX_DIVISOR);
    end else begin
      keff = KW'(div_q);
    end
  end

  // Hold off new words while the table sweep runs
  assign s_axis_tready_o = fr_ready && !bk_stat.sweeping;

  ssdc_front #(
    .MAX_DIVISOR(MAX_DIVISOR)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i && !bk_stat.sweeping),
    .in_ready_o   (fr_ready),
    .in_value_i   (s_axis_tdata_i),
    .in_first_i   (s_axis_tuser_i),
    .k_i          (keff),
    .out_valid_o  (fr_valid),
    .out_ready_i  (q_push_ready),
    .out_residue_o(fr_residue),
    .out_first_o  (fr_first)
  );

  ssdc_queue #(
    .W(RW + 1)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fr_valid),
    .push_ready_o(q_push_ready),
    .push_data_i ({fr_first, fr_residue}),
    .pop_valid_o (q_pop_valid),
    .pop_ready_i (q_pop_ready),
    .pop_data_o  (q_pop_data)
  );

  ssdc_back #(
    .MAX_DIVISOR(MAX_DIVISOR)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .k_i        (keff),
    .q_valid_i  (q_pop_valid),
    .q_ready_o  (q_pop_ready),
    .q_residue_i(q_pop_data[RW-1:0]),
    .q_first_i  (q_pop_data[RW]),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (m_axis_tdata_o),
    .status_o   (bk_stat)
  );

  // The back never takes a queued word mid-sweep
  a_sweep_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.sweeping |-> !(q_pop_valid && q_pop_ready))
    else $error("queue popped during table sweep");

  // The front works on one word at a time
  a_front_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("front accepted a word while busy");

  // A result appears only right after the table update
  a_out_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(bk_stat.finishing))
    else $error("result raised outside the table update");

endmodule
